// ===== rtl/bdeq_pkg.sv =====
// Package for the bounded double-ended queue.
// Holds sizes, action and status codes, state encoding and the ring index helper.
// No dependencies.
`timescale 1ns / 1ps

package bdeq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_CLEAR      = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_t;

  // base + off modulo DEPTH, both below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/bdeq_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Read during write to the same entry returns the old contents. No dependencies.
`timescale 1ns / 1ps

module bdeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                        rdata_a,
  output logic [WIDTH-1:0]                        rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== rtl/bounded_double_ended_queue_top.sv =====
// Bounded double-ended queue of signed words held in a ring RAM.
// Depends on bdeq_pkg and bdeq_ram.
//
// Usage:
//   Request channel in_valid/in_ready carries in_action (push front, push back,
//   pop front, pop back, clear) and in_value (the word for pushes).
//   Result channel out_valid/out_ready returns one result per request: front and
//   back words after the action (0 when empty), entry count, empty and full flags
//   and a status code (ok, underflow on pop, overflow on push).
//   On acceptance, head and count update and any push is written to the RAM while
//   both end entries of the new queue are read, with the written word forwarded.
//   The result state then loads the result register from the registered RAM read
//   data once the output is free; in_ready stays low until that load, so a new
//   request is taken only after the previous result has been loaded.
//   A request is taken while an earlier result still waits in the output register.
//   If the receiver stalls, the finished result holds, the next request waits in
//   its result cycle, and no further request is taken until the output frees.
//   Reset empties the queue (head and count to zero); RAM contents are kept.
`timescale 1ns / 1ps

module bounded_double_ended_queue_top
  import bdeq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_action,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_front_value,
  output logic signed [DATA_W-1:0] out_back_value,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic                     out_is_empty,
  output logic                     out_is_full,
  output logic [1:0]               out_status
);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             front_hit_r, back_hit_r;
  logic [DATA_W-1:0] wdata_r;

  logic              acc;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  faddr;
  logic [IDX_W-1:0]  baddr;
  logic [CNT_W-1:0]  cnt_m1;
  logic [DATA_W-1:0] rd_front;
  logic [DATA_W-1:0] rd_back;
  logic              load_out;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_front_r;
  logic signed [DATA_W-1:0] out_back_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic                     out_empty_r;
  logic                     out_full_r;
  logic [1:0]               out_status_r;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  // next queue state and RAM write
  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    we         = 1'b0;
    waddr      = ring_add(head_r, cnt_r[IDX_W-1:0]);
    if (acc) begin
      unique case (in_action)
        ACT_PUSH_FRONT: begin
          if (cnt_r >= DEPTH_C) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            head_nxt = (head_r == '0) ? LAST_IDX : head_r - IDX_W'(1);
            waddr    = head_nxt;
            we       = 1'b1;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
        ACT_PUSH_BACK: begin
          if (cnt_r >= DEPTH_C) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            we      = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        ACT_POP_FRONT: begin
          if (cnt_r == '0) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            head_nxt = ring_add(head_r, IDX_W'(1));
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
        end
        ACT_POP_BACK: begin
          if (cnt_r == '0) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
        ACT_CLEAR: begin
          head_nxt = '0;
          cnt_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // end entries of the queue after this request
  assign cnt_m1 = (cnt_nxt == '0) ? '0 : cnt_nxt - CNT_W'(1);
  assign faddr  = head_nxt;
  assign baddr  = ring_add(head_nxt, cnt_m1[IDX_W-1:0]);

  bdeq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (in_value),
    .raddr_a (faddr),
    .raddr_b (baddr),
    .rdata_a (rd_front),
    .rdata_b (rd_back)
  );

  assign load_out = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold request details for the result cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      status_r    <= status_nxt;
      front_hit_r <= we && (waddr == faddr);
      back_hit_r  <= we && (waddr == baddr);
      wdata_r     <= in_value;
    end
    if (load_out) begin
      out_front_r  <= (cnt_r == '0) ? '0 : (front_hit_r ? wdata_r : rd_front);
      out_back_r   <= (cnt_r == '0) ? '0 : (back_hit_r ? wdata_r : rd_back);
      out_cnt_r    <= cnt_r;
      out_empty_r  <= (cnt_r == '0);
      out_full_r   <= (cnt_r >= DEPTH_C);
      out_status_r <= status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;
  assign out_entry_count = out_cnt_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;
  assign out_status      = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("fill count beyond depth");

  a_acc_resp: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r == S_RESP) && !in_ready)
    else $error("accepted request did not enter result cycle");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid && (out_entry_count == $past(cnt_r)))
    else $error("result not presented after load");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_front_value == '0) && (out_back_value == '0)
                                  && (out_entry_count == '0))
    else $error("empty result carries data");

  a_write_on_acc: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> acc && ((in_action == ACT_PUSH_FRONT) || (in_action == ACT_PUSH_BACK)))
    else $error("RAM written without a push request");

endmodule

// ===== test/tb.sv =====
// Testbench for bounded_double_ended_queue_top: directed and random requests against a
// behavioural model of the ring-buffer deque, each result checked field by field.
// Depends on bdeq_pkg and the RTL of the queue.
`timescale 1ns / 1ps

module tb;
  import bdeq_pkg::*;

  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
  localparam int RANDOM_REQUESTS = 640;
  localparam int DRAIN_CYCLES    = 20;

  typedef struct {
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
    logic [CNT_W-1:0]         count;
    logic                     empty;
    logic                     full;
    logic [1:0]               status;
  } deq_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [2:0]               in_action;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_back_value;
  logic [CNT_W-1:0]         out_entry_count;
  logic                     out_is_empty;
  logic                     out_is_full;
  logic [1:0]               out_status;

  logic signed [DATA_W-1:0] ring_words [DEPTH];
  logic [IDX_W-1:0]         head_pos;
  logic [CNT_W-1:0]         fill;

  deq_result_t expected_results [$];
  int          mismatches;
  bit          idling_on;
  int          hold_off_request;
  int          stall_left;

  bounded_double_ended_queue_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int slot_of(input int offset);
    return (int'(head_pos) + offset) % DEPTH;
  endfunction

  function automatic deq_result_t apply_action(input logic [2:0] act,
                                               input logic signed [DATA_W-1:0] val);
    deq_result_t r;
    r.status = ST_OK;
    case (act)
      ACT_PUSH_FRONT: begin
        if (fill == DEPTH_C) begin
          r.status = ST_OVERFLOW;
        end else begin
          head_pos = (head_pos == '0) ? LAST_IDX : head_pos - 1'b1;
          ring_words[head_pos] = val;
          fill++;
        end
      end
      ACT_PUSH_BACK: begin
        if (fill == DEPTH_C) begin
          r.status = ST_OVERFLOW;
        end else begin
          ring_words[slot_of(int'(fill))] = val;
          fill++;
        end
      end
      ACT_POP_FRONT: begin
        if (fill == '0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          head_pos = IDX_W'(slot_of(1));
          fill--;
        end
      end
      ACT_POP_BACK: begin
        if (fill == '0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          fill--;
        end
      end
      ACT_CLEAR: begin
        head_pos = '0;
        fill = '0;
      end
      default: begin
      end
    endcase
    r.front = '0;
    r.back  = '0;
    if (fill != '0) begin
      r.front = ring_words[head_pos];
      r.back  = ring_words[slot_of(int'(fill) - 1)];
    end
    r.count = fill;
    r.empty = (fill == '0);
    r.full  = (fill == DEPTH_C);
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      return $urandom_range(1, 3);
    end else if (roll < 95) begin
      return $urandom_range(4, 8);
    end
    return $urandom_range(15, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] random_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      return $urandom;
    end
    case ($urandom_range(0, 3))
      0: return {1'b0, {(DATA_W-1){1'b1}}};
      1: return {1'b1, {(DATA_W-1){1'b0}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_request(input logic [2:0] act, input logic signed [DATA_W-1:0] val);
    int gap;
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(apply_action(act, val));
    @(negedge clk);
    gap = (idling_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    deq_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = expected_results.pop_front();
        if (out_front_value !== want.front)
          report_mismatch($sformatf("front got %h want %h", out_front_value, want.front));
        if (out_back_value !== want.back)
          report_mismatch($sformatf("back got %h want %h", out_back_value, want.back));
        if (out_entry_count !== want.count)
          report_mismatch($sformatf("count got %0d want %0d", out_entry_count, want.count));
        if (out_is_empty !== want.empty)
          report_mismatch($sformatf("empty got %b want %b", out_is_empty, want.empty));
        if (out_is_full !== want.full)
          report_mismatch($sformatf("full got %b want %b", out_is_full, want.full));
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ready = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_request != 0) begin
        stall_left = hold_off_request;
        hold_off_request = 0;
      end else if (stall_left == 0 && idling_on && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_empty_queue();
    send_request(ACT_POP_FRONT, random_word());
    send_request(ACT_POP_BACK, random_word());
    send_request(ACT_SPARE_FIRST, random_word());
  endtask

  task automatic test_fill_and_overflow();
    send_request(ACT_PUSH_BACK, {1'b0, {(DATA_W-1){1'b1}}});
    send_request(ACT_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
    send_request(ACT_PUSH_BACK, '0);
    send_request(ACT_PUSH_FRONT, '1);
    for (int i = 4; i < DEPTH; i++) begin
      send_request((i % 2 == 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, random_word());
    end
    send_request(ACT_PUSH_FRONT, random_word());
    send_request(ACT_PUSH_BACK, random_word());
    send_request(ACT_SPARE_LAST, random_word());
  endtask

  task automatic test_drain_and_clear();
    send_request(ACT_POP_BACK, random_word());
    send_request(ACT_POP_FRONT, random_word());
    send_request(ACT_CLEAR, random_word());
    send_request(ACT_PUSH_FRONT, random_word());
    send_request(ACT_POP_BACK, random_word());
  endtask

  task automatic test_backpressure();
    idling_on = 1'b0;
    hold_off_request = 70;
    for (int i = 0; i < 12; i++) begin
      send_request(logic'($urandom_range(0, 1)) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                   random_word());
    end
    idling_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int mode;
    int roll;
    logic [2:0] act;
    mode = 0;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 40 == 0) begin
        mode = $urandom_range(0, 2);
      end
      if (i % 50 == 0) begin
        idling_on = ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        act = ACT_CLEAR;
      end else if (roll < 6) begin
        act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
      end else begin
        roll = $urandom_range(0, 99);
        if ((mode == 0 && roll < 70) || (mode == 1 && roll < 30) || (mode == 2 && roll < 50))
          act = logic'($urandom_range(0, 1)) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        else
          act = logic'($urandom_range(0, 1)) ? ACT_POP_BACK : ACT_POP_FRONT;
      end
      send_request(act, random_word());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_PUSH_FRONT;
    in_value = '0;
    mismatches = 0;
    idling_on = 1'b0;
    hold_off_request = 0;
    head_pos = '0;
    fill = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_fill_and_overflow();
    test_drain_and_clear();
    idling_on = 1'b1;
    test_backpressure();
    test_random_traffic();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bdeq_pkg.sv
rtl/bdeq_ram.sv
rtl/bounded_double_ended_queue_top.sv
test/tb.sv
